// ===== rtl/hpidx_pkg.sv =====
`default_nettype none

package hpidx_pkg;

  // static table size
  localparam int unsigned StaticEntries = 61;

  // decoder phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CONT = 2'd1;
  localparam logic [1:0] PH_HALT = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_STATIC  = 3'd0;
  localparam logic [2:0] KIND_DYNAMIC = 3'd1;
  localparam logic [2:0] KIND_SIZE    = 3'd2;
  localparam logic [2:0] KIND_ERROR   = 3'd3;
  localparam logic [2:0] KIND_DONE    = 3'd4;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_INCOMPLETE = 3'd1;
  localparam logic [2:0] ERR_TOO_LARGE  = 3'd2;
  localparam logic [2:0] ERR_INDEX_ZERO = 3'd3;
  localparam logic [2:0] ERR_LITERAL    = 3'd4;

  // prefix masks and continuation limit
  localparam logic [6:0] MASK_INDEXED = 7'h7F;
  localparam logic [6:0] MASK_SIZE    = 7'h1F;
  localparam logic [3:0] MAX_CONT     = 4'd8;

  localparam logic [15:0] MAX_FIELDS_RST = 16'd256;

  localparam logic [63:0] STATIC_LAST = 64'(StaticEntries);
  localparam logic [63:0] DYN_BASE    = 64'(StaticEntries + 1);

  // per-block decoder state
  typedef struct packed {
    logic [1:0]  phase;
    logic        is_size;
    logic [63:0] accum;
    logic [3:0]  cont_cnt;
    logic [15:0] fields;
  } hpidx_state_t;

  // one decoded result word
  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [2:0]  err;
    logic        last;
  } hpidx_evt_t;

endpackage

`default_nettype wire

// ===== rtl/hpidx_byte_if.sv =====
`default_nettype none

interface hpidx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_last;

  modport source (output valid, output data_byte, output block_last, input ready);
  modport sink   (input valid, input data_byte, input block_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/hpidx_evt_if.sv =====
`default_nettype none

interface hpidx_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [63:0] event_value;
  logic [2:0]  error_code;
  logic        block_end;

  modport source (output valid, output event_kind, output event_value,
                  output error_code, output block_end, input ready);
  modport sink   (input valid, input event_kind, input event_value,
                  input error_code, input block_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/hpidx_step.sv =====
`default_nettype none

module hpidx_step
  import hpidx_pkg::*;
(
  input  hpidx_state_t cur_i,
  input  logic [7:0]   data_byte_i,
  input  logic         block_last_i,
  input  logic [15:0]  max_fields_i,
  output hpidx_state_t nxt_o,
  output logic         has_evt_o,
  output hpidx_evt_t   evt_o
);

  logic [3:0]   cnt_sat;
  logic [3:0]   cnt_inc;
  logic [5:0]   sh_amt;
  logic [63:0]  digit_sh;
  logic [63:0]  cont_sum;
  logic         do_fin;
  logic         fin_size;
  logic [63:0]  fin_val;
  logic         do_fail;
  logic [2:0]   fail_err;
  logic [6:0]   pfx_val;
  hpidx_state_t nxt_pre;

  // continuation digit weighting
  always_comb begin
    cnt_sat  = (cur_i.cont_cnt > MAX_CONT) ? MAX_CONT : cur_i.cont_cnt;
    cnt_inc  = cnt_sat + 4'd1;
    sh_amt   = 6'(cnt_sat) * 6'd7;
    digit_sh = {57'd0, data_byte_i[6:0]} << sh_amt;
    cont_sum = cur_i.accum + digit_sh;
  end

  // byte classification and integer accumulation
  always_comb begin
    nxt_pre  = cur_i;
    do_fin   = 1'b0;
    fin_size = cur_i.is_size;
    fin_val  = cont_sum;
    do_fail  = 1'b0;
    fail_err = ERR_NONE;
    pfx_val  = '0;
    case (cur_i.phase)
      PH_CONT: begin
        nxt_pre.accum    = cont_sum;
        nxt_pre.cont_cnt = cnt_inc;
        if (!data_byte_i[7]) begin
          do_fin = 1'b1;
        end else if (cnt_inc >= 4'd9) begin
          do_fail  = 1'b1;
          fail_err = ERR_TOO_LARGE;
        end else if (block_last_i) begin
          do_fail  = 1'b1;
          fail_err = ERR_INCOMPLETE;
        end
      end
      PH_IDLE: begin
        if (cur_i.fields < max_fields_i) begin
          if (data_byte_i[7] || data_byte_i[7:5] == 3'b001) begin
            fin_size        = !data_byte_i[7];
            nxt_pre.is_size = fin_size;
            pfx_val         = data_byte_i[7] ? data_byte_i[6:0] : {2'b00, data_byte_i[4:0]};
            fin_val         = {57'd0, pfx_val};
            if (pfx_val != (data_byte_i[7] ? MASK_INDEXED : MASK_SIZE)) begin
              do_fin = 1'b1;
            end else begin
              nxt_pre.accum    = {57'd0, pfx_val};
              nxt_pre.cont_cnt = '0;
              nxt_pre.phase    = PH_CONT;
              if (block_last_i) begin
                do_fail  = 1'b1;
                fail_err = ERR_INCOMPLETE;
              end
            end
          end else begin
            do_fail  = 1'b1;
            fail_err = ERR_LITERAL;
          end
        end
      end
      default: begin
        // halted: bytes ignored
      end
    endcase
  end

  // result selection and block end
  always_comb begin
    nxt_o      = nxt_pre;
    has_evt_o  = 1'b0;
    evt_o      = '0;
    evt_o.last = block_last_i;
    if (do_fin) begin
      has_evt_o   = 1'b1;
      nxt_o.phase = PH_IDLE;
      if (fin_size) begin
        evt_o.kind  = KIND_SIZE;
        evt_o.value = fin_val;
      end else if (fin_val == 64'd0) begin
        nxt_o.phase = PH_HALT;
        evt_o.kind  = KIND_ERROR;
        evt_o.err   = ERR_INDEX_ZERO;
      end else begin
        nxt_o.fields = cur_i.fields + 16'd1;
        if (fin_val <= STATIC_LAST) begin
          evt_o.kind  = KIND_STATIC;
          evt_o.value = fin_val;
        end else begin
          evt_o.kind  = KIND_DYNAMIC;
          evt_o.value = fin_val - DYN_BASE;
        end
      end
    end else if (do_fail) begin
      has_evt_o   = 1'b1;
      nxt_o.phase = PH_HALT;
      evt_o.kind  = KIND_ERROR;
      evt_o.err   = fail_err;
    end
    if (block_last_i) begin
      if (!has_evt_o) begin
        has_evt_o  = 1'b1;
        evt_o.kind = KIND_DONE;
      end
      nxt_o = '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hpack_indexed_field_decoder.sv =====
`default_nettype none

// an accepted byte passes the input register, then the result register, before its result word is valid
// throughput: one byte per cycle; stalls only when the result register is full and not taken
// bytes that cause no result still pass the input register but produce no output word
// reset (rst_ni low, async): decoder idle, all counters zero, max_fields back to 256
module hpack_indexed_field_decoder
  import hpidx_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  hpidx_byte_if.sink       byte_i,
  hpidx_evt_if.source      evt_o
);

  logic         in_v_q;
  logic [7:0]   in_byte_q;
  logic         in_last_q;
  logic         out_v_q;
  hpidx_evt_t   out_q;
  hpidx_state_t st_q;
  hpidx_state_t st_d;
  logic [15:0]  max_fields_q;
  logic         has_evt;
  hpidx_evt_t   evt_d;
  logic         out_free;
  logic         adv;

  assign out_free     = !out_v_q || evt_o.ready;
  assign adv          = in_v_q && out_free;
  assign byte_i.ready = !in_v_q || out_free;

  // field limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_fields_q <= MAX_FIELDS_RST;
    end else if (cfg_we_i) begin
      max_fields_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_v_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.data_byte;
      in_last_q <= byte_i.block_last;
    end
  end

  // decode step
  hpidx_step u_step (
    .cur_i        (st_q),
    .data_byte_i  (in_byte_q),
    .block_last_i (in_last_q),
    .max_fields_i (max_fields_q),
    .nxt_o        (st_d),
    .has_evt_o    (has_evt),
    .evt_o        (evt_d)
  );

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= adv && has_evt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && has_evt) begin
      out_q <= evt_d;
    end
  end

  assign evt_o.valid       = out_v_q;
  assign evt_o.event_kind  = out_q.kind;
  assign evt_o.event_value = out_q.value;
  assign evt_o.error_code  = out_q.err;
  assign evt_o.block_end   = out_q.last;

endmodule

`default_nettype wire

// ===== tb/hpack_indexed_field_decoder_test.sv =====
`default_nettype none

module hpack_indexed_field_decoder_test
  import hpidx_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // one header byte as offered to the block
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_word_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  hpidx_byte_if byte_ch ();
  hpidx_evt_if  evt_ch ();

  hpack_indexed_field_decoder i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .byte_i      (byte_ch),
    .evt_o       (evt_ch)
  );

  // header bytes waiting for the driver, decoded events waiting for the monitor
  byte_word_t byte_q[$];
  hpidx_evt_t pending_events[$];
  logic [7:0] blk_bytes[$];

  // decoder state as the testbench sees it
  logic [1:0]  dec_phase;
  logic        dec_is_size;
  logic [63:0] dec_accum;
  logic [3:0]  dec_cont;
  logic [15:0] dec_fields;
  logic [15:0] max_fields;

  int         mismatches;
  int         tx_wait;
  int         rx_wait;
  int         queued;
  byte_word_t tx_word;
  hpidx_evt_t want;
  logic       calm;
  logic       hold_go;
  logic       stall_hold;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle cycles before the next word, with runs of back-to-back words
  function automatic int draw_wait();
    int r;
    r = $urandom_range(0, 9);
    if (calm || r < 5) return 0;
    if (r < 8) return $urandom_range(1, 3);
    return $urandom_range(0, 19);
  endfunction

  // error result, rest of the block ignored
  task automatic halt_on(input logic [2:0] code, inout hpidx_evt_t ev);
    dec_phase = PH_HALT;
    ev.kind   = KIND_ERROR;
    ev.value  = '0;
    ev.err    = code;
  endtask

  // completed prefix integer
  task automatic close_integer(input logic [63:0] v, inout hpidx_evt_t ev);
    dec_phase = PH_IDLE;
    if (dec_is_size) begin
      ev.kind  = KIND_SIZE;
      ev.value = v;
    end else if (v == 64'd0) begin
      halt_on(ERR_INDEX_ZERO, ev);
    end else begin
      dec_fields = dec_fields + 16'd1;
      if (v <= STATIC_LAST) begin
        ev.kind  = KIND_STATIC;
        ev.value = v;
      end else begin
        ev.kind  = KIND_DYNAMIC;
        ev.value = v - DYN_BASE;
      end
    end
  endtask

  // predict the event caused by one accepted byte
  task automatic decode_byte(input logic [7:0] b, input logic last);
    hpidx_evt_t ev;
    logic       have;
    logic [3:0] c;
    logic [6:0] mask;
    logic [6:0] pre;
    ev      = '0;
    ev.last = last;
    have    = 1'b0;
    if (dec_phase == PH_CONT) begin
      c = (dec_cont > MAX_CONT) ? MAX_CONT : dec_cont;
      dec_accum = dec_accum + ({57'd0, b[6:0]} << (7 * c));
      dec_cont  = c + 4'd1;
      have = 1'b1;
      if (!b[7]) close_integer(dec_accum, ev);
      else if (dec_cont >= 4'd9) halt_on(ERR_TOO_LARGE, ev);
      else if (last) halt_on(ERR_INCOMPLETE, ev);
      else have = 1'b0;
    end else if (dec_phase == PH_IDLE && dec_fields < max_fields) begin
      have = 1'b1;
      if (b[7] || b[7:5] == 3'b001) begin
        dec_is_size = !b[7];
        mask = b[7] ? MASK_INDEXED : MASK_SIZE;
        pre  = b[6:0] & mask;
        if (pre < mask) begin
          close_integer({57'd0, pre}, ev);
        end else begin
          dec_accum = {57'd0, mask};
          dec_cont  = 4'd0;
          dec_phase = PH_CONT;
          if (last) halt_on(ERR_INCOMPLETE, ev);
          else have = 1'b0;
        end
      end else begin
        halt_on(ERR_LITERAL, ev);
      end
    end
    // last byte always reports and clears the block state
    if (last) begin
      if (!have) begin
        ev.kind = KIND_DONE;
        have = 1'b1;
      end
      dec_phase   = PH_IDLE;
      dec_is_size = 1'b0;
      dec_accum   = '0;
      dec_cont    = '0;
      dec_fields  = '0;
    end
    if (have) pending_events = {pending_events, ev};
  endtask

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // driver: offers queued bytes, predicts on every accepted word
  always @(posedge clk) begin
    if (!rst_n) begin
      byte_ch.valid <= 1'b0;
      tx_wait = draw_wait();
    end else begin
      if (byte_ch.valid && byte_ch.ready) decode_byte(byte_ch.data_byte, byte_ch.block_last);
      if (!byte_ch.valid || byte_ch.ready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          byte_ch.valid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          tx_word = byte_q.pop_front();
          byte_ch.valid      <= 1'b1;
          byte_ch.data_byte  <= tx_word.data;
          byte_ch.block_last <= tx_word.last;
          tx_wait = draw_wait();
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each result word with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      evt_ch.ready <= 1'b0;
      rx_wait = draw_wait();
    end else begin
      if (evt_ch.valid && evt_ch.ready) begin
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected word, expected none, got kind %0d value %0h err %0d end %0b",
                   $time, evt_ch.event_kind, evt_ch.event_value, evt_ch.error_code,
                   evt_ch.block_end);
          mismatches++;
        end else begin
          want = pending_events.pop_front();
          check_field("event_kind", 64'(want.kind), 64'(evt_ch.event_kind));
          check_field("event_value", want.value, evt_ch.event_value);
          check_field("error_code", 64'(want.err), 64'(evt_ch.error_code));
          check_field("block_end", 64'(want.last), 64'(evt_ch.block_end));
        end
        rx_wait = draw_wait();
      end
      if (stall_hold) begin
        evt_ch.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        evt_ch.ready <= 1'b0;
      end else begin
        evt_ch.ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    stall_hold = 1'b0;
    wait (hold_go);
    @(posedge clk);
    stall_hold <= 1'b1;
    repeat (300) @(posedge clk);
    stall_hold <= 1'b0;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic push_word(input logic [7:0] b, input logic last);
    byte_word_t w;
    w.data = b;
    w.last = last;
    byte_q = {byte_q, w};
    queued++;
  endtask

  // append one byte to the block being built
  task automatic add_byte(input logic [7:0] b);
    blk_bytes = {blk_bytes, b};
  endtask

  // prefix integer with optional non-minimal zero padding
  task automatic put_int(input logic [7:0] head, input logic [7:0] mask,
                         input logic [63:0] value, input int pad);
    logic [63:0] rest;
    logic [6:0]  digits[$];
    if (value < {56'd0, mask}) begin
      add_byte(head | value[7:0]);
    end else begin
      add_byte(head | mask);
      rest = value - {56'd0, mask};
      do begin
        digits = {digits, rest[6:0]};
        rest = rest >> 7;
      end while (rest != 0);
      repeat (pad) digits = {digits, 7'd0};
      foreach (digits[i])
        add_byte({(i < digits.size() - 1) ? 1'b1 : 1'b0, digits[i]});
    end
  endtask

  function automatic logic [63:0] wide_value();
    return {$urandom, $urandom} >> $urandom_range(0, 63);
  endfunction

  // one representation with random content
  task automatic put_rep();
    int r;
    int n;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      put_int(8'h80, 8'h7F, 64'($urandom_range(1, StaticEntries)), 0);
    end else if (r < 45) begin
      put_int(8'h80, 8'h7F, 64'($urandom_range(62, 4000)), $urandom_range(0, 3) == 0 ?
              $urandom_range(1, 3) : 0);
    end else if (r < 52) begin
      put_int(8'h80, 8'h7F, wide_value(), $urandom_range(0, 2));
    end else if (r < 56) begin
      put_int(8'h80, 8'h7F, 64'd0, 0);
    end else if (r < 70) begin
      put_int(8'h20, 8'h1F, $urandom_range(0, 3) == 0 ? wide_value() :
              64'($urandom_range(0, 65535)), $urandom_range(0, 4) == 0 ? 1 : 0);
    end else if (r < 80) begin
      if ($urandom_range(0, 1) == 1) add_byte(8'($urandom_range(8'h40, 8'h7F)));
      else add_byte(8'($urandom_range(8'h00, 8'h1F)));
    end else if (r < 90) begin
      // long continuation runs around the ninth byte, some saturated
      add_byte($urandom_range(0, 1) ? 8'hFF : 8'h3F);
      n = $urandom_range(7, 10);
      for (int k = 1; k <= n; k++) begin
        b = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
        b[7] = (k != n);
        add_byte(b);
      end
    end else begin
      add_byte(8'($urandom));
    end
  endtask

  // one header block, sometimes cut short anywhere
  task automatic queue_block();
    int cut;
    blk_bytes.delete();
    repeat ($urandom_range(1, 6)) put_rep();
    cut = blk_bytes.size();
    if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, blk_bytes.size());
    for (int i = 0; i < cut; i++) push_word(blk_bytes[i], i == cut - 1);
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || byte_ch.valid || pending_events.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] limit, input logic no_idle, input logic squeeze);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we    <= 1'b0;
    max_fields = limit;
    @(negedge clk);
    calm = no_idle;
    if (squeeze) hold_go = 1'b1;
    queued = 0;
    while (queued < 75) queue_block();
    wait_drained();
    calm = 1'b0;
  endtask

  // stimulus
  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    byte_ch.valid      = 1'b0;
    byte_ch.data_byte  = '0;
    byte_ch.block_last = 1'b0;
    evt_ch.ready       = 1'b0;
    mismatches         = 0;
    calm               = 1'b0;
    hold_go            = 1'b0;
    dec_phase          = PH_IDLE;
    dec_is_size        = 1'b0;
    dec_accum          = '0;
    dec_cont           = '0;
    dec_fields         = '0;
    max_fields         = MAX_FIELDS_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // static edges, first dynamic index, one continuation byte
    push_word(8'h81, 1'b0);
    push_word(8'hBD, 1'b0);
    push_word(8'hBE, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'h00, 1'b1);
    // index zero, then the block is ignored up to its end
    push_word(8'h80, 1'b0);
    push_word(8'h82, 1'b1);
    // size updates: zero and 4096
    push_word(8'h20, 1'b0);
    push_word(8'h3F, 1'b0);
    push_word(8'hE1, 1'b0);
    push_word(8'h1F, 1'b1);
    // literal forms are unsupported
    push_word(8'h40, 1'b0);
    push_word(8'h83, 1'b1);
    push_word(8'h10, 1'b1);
    // block ends inside an integer
    push_word(8'h3F, 1'b1);
    // ninth continuation byte still continuing
    push_word(8'hFF, 1'b0);
    repeat (8) push_word(8'h80, 1'b0);
    push_word(8'h80, 1'b1);
    wait_drained();

    run_phase(16'd65535, 1'b0, 1'b0);
    run_phase(16'd1, 1'b0, 1'b0);
    run_phase(16'd2, 1'b1, 1'b0);
    run_phase(16'($urandom_range(1, 8)), 1'b0, 1'b1);
    run_phase(16'($urandom_range(1, 65535)), 1'b0, 1'b0);
    run_phase(16'd3, 1'b0, 1'b0);

    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/hpidx_pkg.sv
rtl/hpidx_byte_if.sv
rtl/hpidx_evt_if.sv
rtl/hpidx_step.sv
rtl/hpack_indexed_field_decoder.sv
tb/hpack_indexed_field_decoder_test.sv
